### design/adld_pkg.sv
package adld_pkg;

    // Item op codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_GO     = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // Config register indexes
    localparam logic [2:0] CFG_DEPLOY_MIN    = 3'd0;
    localparam logic [2:0] CFG_APOGEE_DROP   = 3'd1;
    localparam logic [2:0] CFG_STABLE_WINDOW = 3'd2;
    localparam logic [2:0] CFG_STABLE_TIME   = 3'd3;
    localparam logic [2:0] CFG_RESTART_DELAY = 3'd4;
    localparam logic [2:0] CFG_AUTO_RESTART  = 3'd5;
    localparam logic [2:0] CFG_SERVO_HOME    = 3'd6;
    localparam logic [2:0] CFG_SERVO_DEPLOY  = 3'd7;

    localparam logic [7:0] SERVO_MAX_ANGLE = 8'd180;
    localparam logic signed [23:0] ALT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] ALT_MIN = 24'sh800000;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        now_ms;
        logic signed [23:0] altitude_cm;
    } t_in;

    typedef struct packed {
        logic [31:0]        flight_time_ms;
        logic signed [23:0] rel_altitude_cm;
        logic               flying;
        logic               deployed;
        logic               landed;
        logic [7:0]         servo_angle;
    } t_out;

    typedef struct packed {
        logic [31:0] deploy_min_time_ms;
        logic [22:0] apogee_drop_cm;
        logic [22:0] stable_window_cm;
        logic [31:0] stable_time_ms;
        logic [31:0] restart_delay_ms;
        logic        auto_restart;
        logic [7:0]  servo_home_angle;
        logic [7:0]  servo_deploy_angle;
    } t_cfg;

    typedef struct packed {
        logic               in_flight;
        logic               chute_out;
        logic               on_ground;
        logic               apogee_seen;
        logic signed [23:0] base_altitude;
        logic signed [23:0] peak_altitude;
        logic signed [23:0] prev_altitude;
        logic [31:0]        launch_ms;
        logic [31:0]        touchdown_ms;
        logic               stable_active;
        logic [31:0]        stable_start_ms;
    } t_state;

endpackage

### design/adld_step.sv
module adld_step
    import adld_pkg::*;
(
    input  t_in    i_item,
    input  t_state i_state,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output t_out   o_res
);

    always_comb begin
        t_state             st;
        logic [31:0]        ftime;
        logic signed [24:0] diff;
        logic signed [23:0] rel;
        logic signed [24:0] drop;
        logic signed [24:0] delta;
        logic [24:0]        delta_abs;
        logic [7:0]         angle;

        st = i_state;

        // Commands act before the result is formed
        case (i_item.op)
            OP_GO: begin
                st.in_flight     = 1'b1;
                st.launch_ms     = i_item.now_ms;
                st.base_altitude = i_item.altitude_cm;
            end
            OP_RESET: begin
                st.in_flight       = 1'b0;
                st.chute_out       = 1'b0;
                st.on_ground       = 1'b0;
                st.apogee_seen     = 1'b0;
                st.peak_altitude   = '0;
                st.prev_altitude   = '0;
                st.launch_ms       = '0;
                st.touchdown_ms    = '0;
                st.stable_active   = 1'b0;
                st.stable_start_ms = '0;
            end
            default: begin
            end
        endcase

        // Flight time and saturated relative altitude
        ftime = i_item.now_ms - st.launch_ms;
        diff  = {i_item.altitude_cm[23], i_item.altitude_cm}
              - {st.base_altitude[23], st.base_altitude};
        if (diff[24] != diff[23]) begin
            rel = diff[24] ? ALT_MIN : ALT_MAX;
        end else begin
            rel = diff[23:0];
        end

        drop      = '0;
        delta     = '0;
        delta_abs = '0;

        if (i_item.op == OP_SAMPLE) begin
            // Peak tracking and apogee deploy
            if (st.in_flight && !st.chute_out && ftime > i_cfg.deploy_min_time_ms) begin
                if (rel > st.peak_altitude) begin
                    st.peak_altitude = rel;
                    st.apogee_seen   = 1'b0;
                end
                drop = {st.peak_altitude[23], st.peak_altitude} - {rel[23], rel};
                if (!st.apogee_seen && drop > $signed({2'b00, i_cfg.apogee_drop_cm})) begin
                    st.apogee_seen = 1'b1;
                    st.chute_out   = 1'b1;
                end
            end

            // Landing: altitude stable for long enough
            if (st.in_flight && st.chute_out) begin
                delta     = {rel[23], rel} - {st.prev_altitude[23], st.prev_altitude};
                delta_abs = delta[24] ? 25'(-delta) : 25'(delta);
                if (delta_abs < {2'b00, i_cfg.stable_window_cm}) begin
                    if (!st.stable_active) begin
                        st.stable_active   = 1'b1;
                        st.stable_start_ms = i_item.now_ms;
                    end else if (i_item.now_ms - st.stable_start_ms
                                 > i_cfg.stable_time_ms) begin
                        st.on_ground    = 1'b1;
                        st.in_flight    = 1'b0;
                        st.touchdown_ms = i_item.now_ms;
                    end
                end else begin
                    st.stable_active = 1'b0;
                end
                st.prev_altitude = rel;
            end

            // Automatic restart after touchdown delay
            if (i_cfg.auto_restart && st.on_ground
                && i_item.now_ms - st.touchdown_ms > i_cfg.restart_delay_ms) begin
                st.in_flight       = 1'b1;
                st.chute_out       = 1'b0;
                st.on_ground       = 1'b0;
                st.apogee_seen     = 1'b0;
                st.peak_altitude   = '0;
                st.prev_altitude   = '0;
                st.launch_ms       = i_item.now_ms;
                st.touchdown_ms    = '0;
                st.stable_active   = 1'b0;
                st.stable_start_ms = '0;
                st.base_altitude   = i_item.altitude_cm;
            end
        end

        // Servo command, clamped
        angle = st.chute_out ? i_cfg.servo_deploy_angle : i_cfg.servo_home_angle;
        if (angle > SERVO_MAX_ANGLE) begin
            angle = SERVO_MAX_ANGLE;
        end

        o_state                 = st;
        o_res.flight_time_ms    = ftime;
        o_res.rel_altitude_cm   = rel;
        o_res.flying            = st.in_flight;
        o_res.deployed          = st.chute_out;
        o_res.landed            = st.on_ground;
        o_res.servo_angle       = angle;
    end

endmodule

### design/apogee_deploy_landing_detector_core.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in)
// out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item is captured in the input register, then the flight state and the
// result register update together as it advances. One item per cycle is
// sustained while the output is not stalled; the flight state is a single
// register set updated as each item retires, so the next item always sees it current.
// Reset (synchronous, active low) clears flight state and loads config defaults.
// A stall on the output holds the result; an empty input register still fills.
module apogee_deploy_landing_detector_core
    import adld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic   r_in_vld;
    t_in    r_in;
    logic   r_out_vld;
    t_out   r_out;
    t_state r_state;
    t_cfg   r_cfg;
    t_cfg   n_cfg;
    t_state n_state;
    t_out   n_out;
    logic   advance;

    // Pipeline control
    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    adld_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // Result register and flight state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Config register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEPLOY_MIN:    n_cfg.deploy_min_time_ms = i_cfg_data;
                CFG_APOGEE_DROP:   n_cfg.apogee_drop_cm     = i_cfg_data[22:0];
                CFG_STABLE_WINDOW: n_cfg.stable_window_cm   = i_cfg_data[22:0];
                CFG_STABLE_TIME:   n_cfg.stable_time_ms     = i_cfg_data;
                CFG_RESTART_DELAY: n_cfg.restart_delay_ms   = i_cfg_data;
                CFG_AUTO_RESTART:  n_cfg.auto_restart       = i_cfg_data[0];
                CFG_SERVO_HOME:    n_cfg.servo_home_angle   = i_cfg_data[7:0];
                CFG_SERVO_DEPLOY:  n_cfg.servo_deploy_angle = i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deploy_min_time_ms <= 32'd1000;
            r_cfg.apogee_drop_cm     <= 23'd100;
            r_cfg.stable_window_cm   <= 23'd50;
            r_cfg.stable_time_ms     <= 32'd2000;
            r_cfg.restart_delay_ms   <= 32'd1000;
            r_cfg.auto_restart       <= 1'b1;
            r_cfg.servo_home_angle   <= 8'd0;
            r_cfg.servo_deploy_angle <= 8'd90;
        end else begin
            r_cfg <= n_cfg;
        end
    end

`ifndef SYNTHESIS
    // Flight state only moves when an item retires
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("flight state changed without a retiring item");

    // Landing is only ever reached with the chute out
    a_land_deployed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.landed |-> o_out_item.deployed)
        else $error("landed reported without deployment");

    // Servo command stays clamped
    a_servo_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.servo_angle <= SERVO_MAX_ANGLE)
        else $error("servo angle beyond clamp");

    // A pending item is never dropped when the output frees up
    a_in_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !r_out_vld |=> o_out_valid)
        else $error("input item did not advance to output");
`endif

endmodule
